// File: rtl/core/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types, opcodes and status codes for the script integer alu.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_FDIV = 4'd3, OP_MOD = 4'd4,
    OP_OR = 4'd5, OP_XOR = 4'd6, OP_AND = 4'd7, OP_LSH = 4'd8, OP_RSH = 4'd9,
    OP_LNOT = 4'd10, OP_POS = 4'd11, OP_NEG = 4'd12, OP_NOT = 4'd13
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_TYPE = 3'd1, ST_DIV0 = 3'd2, ST_RANGE = 3'd3, ST_OPCODE = 3'd4
  } status_t;

  localparam logic [1:0] KIND_BOOL = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [1:0]        left_kind;
    logic signed [31:0] left_value;
    logic [1:0]        right_kind;
    logic signed [31:0] right_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [31:0] value_out;
    logic              is_boolean;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic [3:0]  cmd;
    logic [2:0]  status;   // early error, ST_OK when the back must compute
    logic [31:0] a;
    logic [31:0] b;
  } op_item_t;

endpackage

// File: rtl/core/sia_front.sv
// ----------------------------------------------------------------------------
// sia_front
// Accepts items, normalizes boolean operands and flags type and opcode errors.
// ----------------------------------------------------------------------------
module sia_front import sia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      op_valid,
  input  logic      op_ready,
  output op_item_t  op_data
);

  op_item_t cls;
  logic     lnum, rnum;

  always_comb begin
    lnum = (in_data.left_kind == KIND_BOOL) || (in_data.left_kind == KIND_INT);
    rnum = (in_data.right_kind == KIND_BOOL) || (in_data.right_kind == KIND_INT);
    cls.cmd = in_data.cmd;
    cls.a = (in_data.left_kind == KIND_BOOL) ? {31'd0, |in_data.left_value}
                                             : in_data.left_value;
    cls.b = (in_data.right_kind == KIND_BOOL) ? {31'd0, |in_data.right_value}
                                              : in_data.right_value;
    if (in_data.cmd > OP_NOT) begin
      cls.status = ST_OPCODE;
    end else if (in_data.cmd >= OP_LNOT) begin
      cls.status = lnum ? ST_OK : ST_TYPE;
    end else begin
      cls.status = (lnum && rnum) ? ST_OK : ST_TYPE;
    end
  end

  assign in_ready = !op_valid || op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_data <= cls;
    end
  end

endmodule

// File: rtl/core/sia_queue.sv
// ----------------------------------------------------------------------------
// sia_queue
// Short fifo between the front and the back.
// ----------------------------------------------------------------------------
module sia_queue import sia_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  op_item_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output op_item_t rd_data
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  op_item_t          mem [Depth];
  logic [AW-1:0]     wptr, rptr;
  logic [AW:0]       count;
  logic              wr, rd;

  assign wr_ready = count != (AW+1)'(Depth);
  assign rd_valid = count != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (rd) rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) rd_valid && !rd |=> $stable(rptr))
    else $error("read pointer moved without a pop");
  assert property (@(posedge clk) disable iff (rst) wr && !rd |=> count == $past(count) + 1'b1)
    else $error("count lost a push");

endmodule

// File: rtl/core/sia_back.sv
// ----------------------------------------------------------------------------
// sia_back
// Execution pipeline: one op per cycle when not stalled, radix-2 restoring
// divider with one quotient bit per stage, then floor correction and output register.
// ----------------------------------------------------------------------------
module sia_back import sia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_ready,
  input  op_item_t  op_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned Width = WordW;
  localparam int unsigned NS = Width + 2;  // entry, Width divide stages, finish

  typedef struct packed {
    logic [3:0]       cmd;
    logic [2:0]       status;
    logic [Width-1:0] res;     // finished value for non-divide ops
    logic             isb;
    logic [Width-1:0] rem;     // partial remainder (magnitude)
    logic [Width-1:0] quo;     // dividend shifting out, quotient shifting in
    logic [Width-1:0] dmag;    // divisor magnitude
    logic             qneg;
    logic             aneg;
    logic             bneg;
    logic [Width-1:0] b;
  } stage_t;

  stage_t            st   [NS];
  logic   [NS-1:0]   vld;
  logic              adv;

  // whole pipe moves together when the output slot frees
  assign adv = !out_valid || out_ready;
  assign op_ready = adv;

  // entry: everything but division finishes here
  stage_t ent;
  logic [Width-1:0] a, b, amag, prod;
  logic             bneg_sh, big;

  always_comb begin
    a = op_data.a;
    b = op_data.b;
    amag = a[Width-1] ? (~a + 1'b1) : a;
    prod = a * b;
    bneg_sh = b[Width-1];
    big = |b[Width-1:$clog2(Width)];
    ent = '0;
    ent.cmd = op_data.cmd;
    ent.status = op_data.status;
    ent.b = b;
    ent.aneg = a[Width-1];
    ent.bneg = b[Width-1];
    ent.qneg = a[Width-1] ^ b[Width-1];
    ent.quo = amag;
    ent.dmag = b[Width-1] ? (~b + 1'b1) : b;
    case (op_data.cmd)
      OP_ADD:  ent.res = a + b;
      OP_SUB:  ent.res = a - b;
      OP_MUL:  ent.res = prod;
      OP_FDIV, OP_MOD: begin
        if (b == '0 && op_data.status == ST_OK) ent.status = ST_DIV0;
      end
      OP_OR:   ent.res = a | b;
      OP_XOR:  ent.res = a ^ b;
      OP_AND:  ent.res = a & b;
      OP_LSH: begin
        if (bneg_sh && op_data.status == ST_OK) ent.status = ST_RANGE;
        ent.res = big ? '0 : a << b[$clog2(Width)-1:0];
      end
      OP_RSH: begin
        if (bneg_sh && op_data.status == ST_OK) ent.status = ST_RANGE;
        ent.res = big ? {Width{a[Width-1]}}
                      : Width'($signed(a) >>> b[$clog2(Width)-1:0]);
      end
      OP_LNOT: begin
        ent.res = {{(Width-1){1'b0}}, a == '0};
        ent.isb = 1'b1;
      end
      OP_POS:  ent.res = a;
      OP_NEG:  ent.res = '0 - a;
      OP_NOT:  ent.res = ~a;
      default: ent.res = '0;
    endcase
  end

  // one restoring step per stage
  function automatic stage_t div_step(stage_t s);
    stage_t           o;
    logic [Width:0]   trial;
    o = s;
    trial = {s.rem, s.quo[Width-1]} - {1'b0, s.dmag};
    if (!trial[Width]) begin
      o.rem = trial[Width-1:0];
      o.quo = {s.quo[Width-2:0], 1'b1};
    end else begin
      o.rem = {s.rem[Width-2:0], s.quo[Width-1]};
      o.quo = {s.quo[Width-2:0], 1'b0};
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], op_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= ent;
      for (int i = 1; i < NS; i++) begin
        st[i] <= (i <= Width) ? div_step(st[i-1]) : st[i-1];
      end
    end
  end

  // floor correction on the last stage
  stage_t           fin;
  logic [Width-1:0] q, r, val;

  always_comb begin
    fin = st[NS-1];
    q = fin.qneg ? (~fin.quo + 1'b1) : fin.quo;
    r = fin.aneg ? (~fin.rem + 1'b1) : fin.rem;
    if (r != '0 && fin.qneg) begin
      q = q - 1'b1;
      r = r + fin.b;
    end
    case (fin.cmd)
      OP_FDIV: val = q;
      OP_MOD:  val = r;
      default: val = fin.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.status     <= fin.status;
      out_data.value_out  <= (fin.status == ST_OK) ? val : '0;
      out_data.is_boolean <= (fin.status == ST_OK) && fin.isb;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   out_valid && out_data.status != ST_OK |-> out_data.value_out == '0)
    else $error("error result carries a value");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && out_data.is_boolean |-> out_data.value_out[Width-1:1] == '0)
    else $error("boolean result out of range");
  assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("pipe moved while stalled");

endmodule

// File: rtl/core/script_integer_alu.sv
// path: an accepted input passes the front register, the queue, the 34-stage
// execution pipe and the output register
// throughput: one item per cycle when not stalled; the divider is fully pipelined, a bit a stage
// reset: synchronous rst empties the front register, the queue and the pipe
// ----------------------------------------------------------------------------
// script_integer_alu
// Python-semantics 32-bit integer alu with decoupled front and back.
// ----------------------------------------------------------------------------
module script_integer_alu import sia_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     f_valid, f_ready, q_valid, q_ready;
  op_item_t f_data, q_data;

  sia_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .op_valid(f_valid), .op_ready(f_ready), .op_data(f_data)
  );

  sia_queue #(.Depth(Depth)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  sia_back u_back (
    .clk, .rst,
    .op_valid(q_valid), .op_ready(q_ready), .op_data(q_data),
    .out_valid, .out_ready, .out_data
  );

endmodule
